[hw/rtl/bft_pkg.sv]
// Package for the bidirectional flow table: item, result and table entry types,
// status and register codes, default sizes. No dependencies.
package bft_pkg;

	localparam int BUCKETS_DEF = 256;
	localparam int WAYS_DEF    = 4;
	localparam int MAX_OUT     = 4;

	localparam logic [31:0] IDLE_TO_RST   = 32'd30;
	localparam logic [31:0] ACTIVE_TO_RST = 32'd120;

	// configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TO   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TO = 8'd1;

	localparam logic CMD_PKT   = 1'b0;
	localparam logic CMD_SWEEP = 1'b1;

	typedef enum logic [2:0] {
		STS_FWD      = 3'd0,
		STS_REV      = 3'd1,
		STS_NEW      = 3'd2,
		STS_DROP     = 3'd3,
		STS_EXP_MORE = 3'd4,
		STS_EXP_LAST = 3'd5,
		STS_NONE     = 3'd6
	} status_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  proto;
		logic [15:0] pkt_size;
		logic [31:0] now_seconds;
		logic [7:0]  sweep_bucket;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  flow_proto;
		logic [31:0] flow_addr1;
		logic [15:0] flow_port1;
		logic [31:0] flow_addr2;
		logic [15:0] flow_port2;
		logic [47:0] bytes_fwd;
		logic [31:0] pkts_fwd;
		logic [47:0] bytes_rev;
		logic [31:0] pkts_rev;
		logic [31:0] first_seen;
		logic [31:0] lifetime;
	} result_t;

	// one way of a bucket row
	typedef struct packed {
		logic        valid;
		logic [31:0] addr1;
		logic [31:0] addr2;
		logic [15:0] port1;
		logic [15:0] port2;
		logic [7:0]  proto;
		logic [47:0] bytes_fwd;
		logic [47:0] bytes_rev;
		logic [31:0] pkts_fwd;
		logic [31:0] pkts_rev;
		logic [31:0] start;
		logic [31:0] last;
	} entry_t;

endpackage

[hw/rtl/bft_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/bft_fifo.sv]
// Small flop-based queue (power-of-two depth) used between front and back
// and for results. No dependencies.
module bft_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[hw/rtl/bft_front.sv]
// Front part: accepts items, hashes the tuple and reduces it modulo the bucket
// count in a three-stage pipeline. Depends on bft_pkg.
module bft_front #(
	parameter int BUCKETS = bft_pkg::BUCKETS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         push,
	output logic                                         full,
	input  bft_pkg::item_t                               item,
	input  logic                                         hold,
	output logic                                         mid_push,
	output logic [$bits(bft_pkg::item_t)+$clog2(BUCKETS)-1:0] mid_data,
	input  logic                                         mid_full
);

	import bft_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	// floor(2^32 / BUCKETS); quotient estimate is low by at most one
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);
	localparam logic [17:0] BKT   = 18'(BUCKETS);

	function automatic logic [31:0] mix_fold(input logic [31:0] h);
		return h ^ ({h[15:0], 16'd0} & (~{16'd0, h[31:16]} ^ {16'd0, h[15:0]}));
	endfunction

	function automatic logic [31:0] mix_rot(input logic [31:0] h);
		return h ^ {h[24:0], h[31:25]};
	endfunction

	function automatic logic [31:0] flow_hash(input item_t it);
		logic [31:0] h;
		h = {it.sport, it.dport};
		h = h ^ {h[15:0], h[31:16]};
		h = h ^ it.src_addr ^ it.dst_addr ^ {24'd0, it.proto};
		h = mix_fold(h);
		h = mix_rot(h);
		h = mix_fold(h);
		h = mix_rot(h);
		h = mix_fold(h);
		h = mix_rot(h);
		h = mix_fold(h);
		return h;
	endfunction

	logic        v_s1, v_s2, v_s3;
	item_t       item_s1, item_s2, item_s3;
	logic [31:0] key_s2, key_s3, quo_s3;
	logic        en;
	logic [63:0] prod;
	logic [48:0] qb;
	logic [31:0] rem32;
	logic [17:0] rem, rem_fix;

	// whole pipeline moves unless the last stage is blocked
	assign en       = !(v_s3 && mid_full);
	assign full     = !en || hold;
	assign mid_push = v_s3 && !mid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push && !full;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1 capture, stage 2 hash (sweeps take their bucket field), stage 3 quotient
	assign prod = 64'(key_s2) * 64'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;
			item_s2 <= item_s1;
			key_s2  <= (item_s1.cmd == CMD_SWEEP) ? {24'd0, item_s1.sweep_bucket}
			                                      : flow_hash(item_s1);
			item_s3 <= item_s2;
			key_s3  <= key_s2;
			quo_s3  <= prod[63:32];
		end
	end

	// remainder with one correction step
	assign qb      = 49'(quo_s3) * 49'(BKT);
	assign rem32   = key_s3 - qb[31:0];
	assign rem     = rem32[17:0];
	assign rem_fix = (rem >= BKT) ? rem - BKT : rem;
	assign mid_data = {rem_fix[BW-1:0], item_s3};

endmodule

[hw/rtl/bft_back.sv]
// Back part: clears the table after reset, then reads a bucket row, matches,
// updates or sweeps it and emits results. Depends on bft_pkg, bft_ram.
module bft_back #(
	parameter int BUCKETS = bft_pkg::BUCKETS_DEF,
	parameter int WAYS    = bft_pkg::WAYS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         mid_empty,
	output logic                                         mid_pop,
	input  logic [$bits(bft_pkg::item_t)+$clog2(BUCKETS)-1:0] mid_data,
	input  logic                                         out_full,
	output logic                                         out_push,
	output bft_pkg::result_t                             out_data,
	input  logic [31:0]                                  idle_to,
	input  logic [31:0]                                  active_to,
	output logic                                         clearing
);

	import bft_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	localparam int IW = $bits(item_t);
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NW = $clog2(MAX_OUT + 1);
	localparam int RW = WAYS * $bits(entry_t);

	typedef entry_t [WAYS-1:0] row_t;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_LOOK  = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	function automatic logic [31:0] tdiff(input logic [31:0] later, input logic [31:0] earlier);
		return (later >= earlier) ? later - earlier : 32'd0;
	endfunction

	function automatic result_t mk_result(input status_t st, input entry_t e);
		result_t r;
		r.status     = st;
		r.flow_proto = e.proto;
		r.flow_addr1 = e.addr1;
		r.flow_port1 = e.port1;
		r.flow_addr2 = e.addr2;
		r.flow_port2 = e.port2;
		r.bytes_fwd  = e.bytes_fwd;
		r.pkts_fwd   = e.pkts_fwd;
		r.bytes_rev  = e.bytes_rev;
		r.pkts_rev   = e.pkts_rev;
		r.first_seen = e.start;
		r.lifetime   = tdiff(e.last, e.start);
		return r;
	endfunction

	function automatic logic [47:0] sat48(input logic [47:0] a, input logic [15:0] b);
		logic [48:0] s;
		s = {1'b0, a} + 49'(b);
		return s[48] ? '1 : s[47:0];
	endfunction

	function automatic logic [31:0] inc32(input logic [31:0] a);
		return (&a) ? a : a + 1'b1;
	endfunction

	state_t         state_q;
	logic [BW-1:0]  clr_q, bkt_q;
	item_t          item_q;
	logic [WAYS-1:0] rem_q;
	row_t           row_q;

	logic           start;
	logic [RW-1:0]  rd_bits;
	row_t           rd_row, wr_row;
	logic           ram_we;
	logic [BW-1:0]  ram_waddr;

	logic [WAYS-1:0] hit, fwd_at, exp_mask;
	logic [WW-1:0]  sel_idx, free_idx, emit_idx;
	logic           any_hit, any_free, is_fwd, look_we;
	logic [NW-1:0]  n_exp;
	entry_t         upd, fresh;
	result_t        look_res, emit_res;
	logic [WAYS-1:0] rem_low, rem_next;
	logic           emit_last;

	assign clearing = (state_q == S_CLEAR);
	assign start    = (state_q == S_IDLE) && !mid_empty && !out_full;
	assign mid_pop  = start;
	assign rd_row   = row_t'(rd_bits);

	bft_ram #(.WIDTH(RW), .DEPTH(BUCKETS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (RW'(wr_row)),
		.re    (start),
		.raddr (mid_data[IW +: BW]),
		.rdata (rd_bits)
	);

	// way matching, expiry check and the updated entries
	always_comb begin
		hit      = '0;
		fwd_at   = '0;
		exp_mask = '0;
		n_exp    = '0;
		sel_idx  = '0;
		free_idx = '0;
		any_hit  = 1'b0;
		any_free = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			fwd_at[w] = (item_q.src_addr == rd_row[w].addr1) && (item_q.sport == rd_row[w].port1)
			         && (item_q.dst_addr == rd_row[w].addr2) && (item_q.dport == rd_row[w].port2);
			hit[w] = rd_row[w].valid && (rd_row[w].proto == item_q.proto) && (fwd_at[w]
			      || ((item_q.src_addr == rd_row[w].addr2) && (item_q.sport == rd_row[w].port2)
			       && (item_q.dst_addr == rd_row[w].addr1) && (item_q.dport == rd_row[w].port1)));
			if (hit[w] && !any_hit) begin
				any_hit = 1'b1;
				sel_idx = WW'(w);
			end
			if (!rd_row[w].valid && !any_free) begin
				any_free = 1'b1;
				free_idx = WW'(w);
			end
			if (rd_row[w].valid && n_exp < NW'(MAX_OUT)
			    && (tdiff(item_q.now_seconds, rd_row[w].last) > idle_to
			     || tdiff(rd_row[w].last, rd_row[w].start) > active_to)) begin
				exp_mask[w] = 1'b1;
				n_exp       = n_exp + 1'b1;
			end
		end

		is_fwd = fwd_at[sel_idx];
		upd    = rd_row[sel_idx];
		if (is_fwd) begin
			upd.bytes_fwd = sat48(upd.bytes_fwd, item_q.pkt_size);
			upd.pkts_fwd  = inc32(upd.pkts_fwd);
		end else begin
			upd.bytes_rev = sat48(upd.bytes_rev, item_q.pkt_size);
			upd.pkts_rev  = inc32(upd.pkts_rev);
		end
		upd.last = item_q.now_seconds;

		fresh.valid     = 1'b1;
		fresh.addr1     = item_q.src_addr;
		fresh.addr2     = item_q.dst_addr;
		fresh.port1     = item_q.sport;
		fresh.port2     = item_q.dport;
		fresh.proto     = item_q.proto;
		fresh.bytes_fwd = 48'(item_q.pkt_size);
		fresh.bytes_rev = '0;
		fresh.pkts_fwd  = 32'd1;
		fresh.pkts_rev  = '0;
		fresh.start     = item_q.now_seconds;
		fresh.last      = item_q.now_seconds;
	end

	// write-back row and the single result of a lookup
	always_comb begin
		wr_row   = rd_row;
		look_we  = 1'b0;
		look_res = '0;
		if (item_q.cmd == CMD_SWEEP) begin
			for (int w = 0; w < WAYS; w++) begin
				if (exp_mask[w]) begin
					wr_row[w].valid = 1'b0;
				end
			end
			look_we         = (exp_mask != '0);
			look_res.status = STS_NONE;
		end else if (any_hit) begin
			wr_row[sel_idx] = upd;
			look_we         = 1'b1;
			look_res        = mk_result(is_fwd ? STS_FWD : STS_REV, upd);
		end else if (any_free) begin
			wr_row[free_idx] = fresh;
			look_we          = 1'b1;
			look_res         = mk_result(STS_NEW, fresh);
		end else begin
			look_res.status     = STS_DROP;
			look_res.flow_proto = item_q.proto;
			look_res.flow_addr1 = item_q.src_addr;
			look_res.flow_port1 = item_q.sport;
			look_res.flow_addr2 = item_q.dst_addr;
			look_res.flow_port2 = item_q.dport;
			look_res.first_seen = item_q.now_seconds;
		end
		if (state_q == S_CLEAR) begin
			wr_row = '0;
		end
	end

	assign ram_we    = clearing || ((state_q == S_LOOK) && look_we);
	assign ram_waddr = clearing ? clr_q : bkt_q;

	// expired flows go out one per cycle while the result queue is not full, lowest way first
	assign rem_low   = rem_q & (~rem_q + 1'b1);
	assign rem_next  = rem_q & ~rem_low;
	assign emit_last = (rem_next == '0);

	always_comb begin
		emit_idx = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (rem_low[w]) begin
				emit_idx = WW'(w);
			end
		end
		emit_res = mk_result(emit_last ? STS_EXP_LAST : STS_EXP_MORE, row_q[emit_idx]);
	end

	always_comb begin
		out_push = 1'b0;
		out_data = look_res;
		case (state_q)
			S_LOOK: begin
				out_push = (item_q.cmd == CMD_PKT) || (exp_mask == '0);
			end
			S_EMIT: begin
				out_push = !out_full;
				out_data = emit_res;
			end
			default: begin
				out_push = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (item_q.cmd == CMD_SWEEP && exp_mask != '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (!out_full && emit_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item, bucket and sweep bookkeeping
	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= item_t'(mid_data[IW-1:0]);
			bkt_q  <= mid_data[IW +: BW];
		end
		if (state_q == S_LOOK) begin
			rem_q <= exp_mask;
			row_q <= rd_row;
		end else if (state_q == S_EMIT && !out_full) begin
			rem_q <= rem_next;
		end
	end

endmodule

[hw/rtl/bidirectional_flow_table.sv]
// Top level of the bidirectional flow table: configuration registers, front,
// queues and back. Depends on bft_pkg, bft_front, bft_fifo, bft_back.
//
// Usage:
//  Input queue: present an item on item with push; it transfers when full is
//  low. cmd 0 is a packet (forward/reverse update, create or drop), cmd 1
//  sweeps one bucket for idle or active timeouts.
//  Result queue: while empty is low the oldest result is on result; pop
//  transfers it. A packet gives one result, a sweep one to four.
//  Configuration: cfg_valid with cfg_index/cfg_data; cfg_ready is always high.
//  Index 0 idle timeout, 1 active timeout, other indexes ignored.
// Path: an item passes the front pipeline (capture, hash, reciprocal quotient)
//  into the middle queue; the back then reads the bucket row from the table
//  RAM, writes it back and pushes the result into the result queue. A sweep
//  that reports expired flows then emits them one at a time. The back takes
//  no new item until it is through with the previous one.
// Reset: all queues empty, timeouts 30 and 120; then a clearing pass writes
//  every bucket row, with full held high meanwhile.
// A stalled result side fills the result queue; the back then waits, the
//  middle queue fills and full rises.
module bidirectional_flow_table #(
	parameter int BUCKETS = bft_pkg::BUCKETS_DEF,
	parameter int WAYS    = bft_pkg::WAYS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  bft_pkg::item_t                  item,
	output logic                            empty,
	input  logic                            pop,
	output bft_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bft_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);

	import bft_pkg::*;

	localparam int MW = $bits(item_t) + $clog2(BUCKETS);
	localparam int OW = $bits(result_t);

	logic [31:0]   idle_to_q, active_to_q;
	logic          clearing;
	logic          mid_push, mid_full, mid_pop, mid_empty;
	logic [MW-1:0] mid_wdata, mid_rdata;
	logic          out_push, out_full;
	result_t       out_data;
	logic [OW-1:0] out_rdata;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_to_q   <= IDLE_TO_RST;
			active_to_q <= ACTIVE_TO_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IDLE_TO:   idle_to_q   <= cfg_data;
				REG_ACTIVE_TO: active_to_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bft_front #(.BUCKETS(BUCKETS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.hold     (clearing),
		.mid_push (mid_push),
		.mid_data (mid_wdata),
		.mid_full (mid_full)
	);

	bft_fifo #(.WIDTH(MW), .DEPTH(2)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	bft_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.mid_data  (mid_rdata),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_data),
		.idle_to   (idle_to_q),
		.active_to (active_to_q),
		.clearing  (clearing)
	);

	bft_fifo #(.WIDTH(OW), .DEPTH(4)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (OW'(out_data)),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign result = result_t'(out_rdata);

	// no transfer is taken while the table is being cleared
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("input open during table clear");

	// the back never pushes into a full result queue
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue overflow");

	// a bucket read is followed by no second read in the next cycle
	a_back_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |=> !mid_pop)
		else $error("back started two items back to back");

	// the back only takes from a non-empty middle queue
	a_mid_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("middle queue underflow");

endmodule

[verif/tb_bidirectional_flow_table.sv]
// Self-checking testbench for the bidirectional flow table: drives packet and
// sweep items, predicts results with a local table model and checks them.
// Depends on bft_pkg and bidirectional_flow_table.
`timescale 1ns / 1ps

module tb_bidirectional_flow_table;
	import bft_pkg::*;

	localparam int NB = 256;
	localparam int NW = 4;
	localparam int LIMIT = 400000;
	localparam int HOLD_LEN = 300;
	// an index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	bidirectional_flow_table dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] idle_to = IDLE_TO_RST;
	logic [31:0] active_to = ACTIVE_TO_RST;
	entry_t flow_tab [NB*NW];

	item_t pending_items [$];
	result_t expected_results [$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 25;
	int recv_idle_pct = 64;
	bit hold_req = 1'b0;
	int hold_cycles = 0;
	logic hold_pop;
	bit cfg_busy = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx_q;
	logic [31:0] cfg_data_q;

	function automatic logic [31:0] fold32(logic [31:0] h);
		return h ^ ((h << 16) & (~(h >> 16) ^ (h & 32'h0000ffff)));
	endfunction

	function automatic logic [31:0] rot32(logic [31:0] h);
		return h ^ {h[24:0], h[31:25]};
	endfunction

	function automatic int bucket_hash(item_t it);
		logic [31:0] h;
		h = {it.sport, it.dport};
		h ^= {h[15:0], h[31:16]};
		h = h ^ it.src_addr ^ it.dst_addr ^ {24'd0, it.proto};
		h = fold32(h); h = rot32(h); h = fold32(h); h = rot32(h);
		h = fold32(h); h = rot32(h); h = fold32(h);
		return int'(h % NB);
	endfunction

	function automatic logic [31:0] elapsed(logic [31:0] later, logic [31:0] earlier);
		return (later >= earlier) ? later - earlier : 32'd0;
	endfunction

	function automatic result_t flow_report(status_t st, int s);
		result_t r;
		r.status = st;
		r.flow_proto = flow_tab[s].proto;
		r.flow_addr1 = flow_tab[s].addr1;
		r.flow_port1 = flow_tab[s].port1;
		r.flow_addr2 = flow_tab[s].addr2;
		r.flow_port2 = flow_tab[s].port2;
		r.bytes_fwd = flow_tab[s].bytes_fwd;
		r.pkts_fwd = flow_tab[s].pkts_fwd;
		r.bytes_rev = flow_tab[s].bytes_rev;
		r.pkts_rev = flow_tab[s].pkts_rev;
		r.first_seen = flow_tab[s].start;
		r.lifetime = elapsed(flow_tab[s].last, flow_tab[s].start);
		return r;
	endfunction

	function automatic logic [47:0] add_sat48(logic [47:0] a, logic [15:0] b);
		logic [48:0] s;
		s = a + b;
		return s[48] ? 48'hffffffffffff : s[47:0];
	endfunction

	function automatic logic [31:0] inc_sat32(logic [31:0] a);
		return (a == 32'hffffffff) ? a : a + 1;
	endfunction

	// table update for one accepted item; pushes the results it causes
	task automatic predict_flow(item_t it);
		int b, s, freeslot, hits[$];
		result_t r;
		if (it.cmd == CMD_SWEEP) begin
			b = int'(it.sweep_bucket) % NB;
			for (int w = 0; w < NW && hits.size() < MAX_OUT; w++) begin
				s = b*NW + w;
				if (flow_tab[s].valid &&
					(elapsed(it.now_seconds, flow_tab[s].last) > idle_to ||
					elapsed(flow_tab[s].last, flow_tab[s].start) > active_to))
					hits.push_back(s);
			end
			if (hits.size() == 0) begin
				r = '0;
				r.status = STS_NONE;
				expected_results.push_back(r);
			end
			foreach (hits[i]) begin
				expected_results.push_back(flow_report(
					(i == hits.size()-1) ? STS_EXP_LAST : STS_EXP_MORE, hits[i]));
				flow_tab[hits[i]].valid = 1'b0;
			end
			return;
		end
		b = bucket_hash(it);
		freeslot = -1;
		for (int w = 0; w < NW; w++) begin
			s = b*NW + w;
			if (!flow_tab[s].valid) begin
				if (freeslot < 0) freeslot = s;
				continue;
			end
			if (flow_tab[s].proto != it.proto) continue;
			if (it.src_addr == flow_tab[s].addr1 && it.sport == flow_tab[s].port1 &&
				it.dst_addr == flow_tab[s].addr2 && it.dport == flow_tab[s].port2) begin
				flow_tab[s].bytes_fwd = add_sat48(flow_tab[s].bytes_fwd, it.pkt_size);
				flow_tab[s].pkts_fwd = inc_sat32(flow_tab[s].pkts_fwd);
				flow_tab[s].last = it.now_seconds;
				expected_results.push_back(flow_report(STS_FWD, s));
				return;
			end
			if (it.src_addr == flow_tab[s].addr2 && it.sport == flow_tab[s].port2 &&
				it.dst_addr == flow_tab[s].addr1 && it.dport == flow_tab[s].port1) begin
				flow_tab[s].bytes_rev = add_sat48(flow_tab[s].bytes_rev, it.pkt_size);
				flow_tab[s].pkts_rev = inc_sat32(flow_tab[s].pkts_rev);
				flow_tab[s].last = it.now_seconds;
				expected_results.push_back(flow_report(STS_REV, s));
				return;
			end
		end
		if (freeslot < 0) begin
			r = '0;
			r.status = STS_DROP;
			r.flow_proto = it.proto;
			r.flow_addr1 = it.src_addr;
			r.flow_port1 = it.sport;
			r.flow_addr2 = it.dst_addr;
			r.flow_port2 = it.dport;
			r.first_seen = it.now_seconds;
			expected_results.push_back(r);
			return;
		end
		flow_tab[freeslot] = '{valid: 1'b1, addr1: it.src_addr, addr2: it.dst_addr,
			port1: it.sport, port2: it.dport, proto: it.proto,
			bytes_fwd: 48'(it.pkt_size), bytes_rev: '0, pkts_fwd: 32'd1, pkts_rev: '0,
			start: it.now_seconds, last: it.now_seconds};
		expected_results.push_back(flow_report(STS_NEW, freeslot));
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("MISMATCH %s: got %0h expected %0h", what, got, want);
	endtask

	// driver: offers queued items, updates prediction on each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_flow(item);
				void'(pending_items.pop_front());
			end
			if (pending_items.size() > 0 && ($urandom_range(99) >= send_idle_pct ||
				(push && full))) begin
				push <= 1'b1;
				item <= pending_items[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver hold-off: counts its own cycles once requested
	assign hold_pop = hold_req && (hold_cycles < HOLD_LEN);

	always @(posedge clk) begin
		if (hold_pop) hold_cycles++;
	end

	// monitor: checks each result transfer against the oldest expectation
	always @(posedge clk) begin
		result_t w;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", 64'(result.status), 64'd0);
				end else begin
					w = expected_results.pop_front();
					if (result.status != w.status)
						report_mismatch("status", result.status, w.status);
					if (result.flow_proto != w.flow_proto)
						report_mismatch("proto", result.flow_proto, w.flow_proto);
					if (result.flow_addr1 != w.flow_addr1)
						report_mismatch("addr1", result.flow_addr1, w.flow_addr1);
					if (result.flow_port1 != w.flow_port1)
						report_mismatch("port1", result.flow_port1, w.flow_port1);
					if (result.flow_addr2 != w.flow_addr2)
						report_mismatch("addr2", result.flow_addr2, w.flow_addr2);
					if (result.flow_port2 != w.flow_port2)
						report_mismatch("port2", result.flow_port2, w.flow_port2);
					if (result.bytes_fwd != w.bytes_fwd)
						report_mismatch("bytes_fwd", result.bytes_fwd, w.bytes_fwd);
					if (result.pkts_fwd != w.pkts_fwd)
						report_mismatch("pkts_fwd", result.pkts_fwd, w.pkts_fwd);
					if (result.bytes_rev != w.bytes_rev)
						report_mismatch("bytes_rev", result.bytes_rev, w.bytes_rev);
					if (result.pkts_rev != w.pkts_rev)
						report_mismatch("pkts_rev", result.pkts_rev, w.pkts_rev);
					if (result.first_seen != w.first_seen)
						report_mismatch("first_seen", result.first_seen, w.first_seen);
					if (result.lifetime != w.lifetime)
						report_mismatch("lifetime", result.lifetime, w.lifetime);
				end
			end
			pop <= !hold_pop && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// configuration channel: one write per request, mirrored into the predictor
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_IDLE_TO) idle_to = cfg_data;
			else if (cfg_index == REG_ACTIVE_TO) active_to = cfg_data;
			cfg_valid <= 1'b0;
			cfg_busy = 1'b0;
		end else if (cfg_busy && !cfg_valid) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_q;
			cfg_data <= cfg_data_q;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_idx_q = idx;
		cfg_data_q = val;
		cfg_busy = 1'b1;
		while (cfg_busy) @(posedge clk);
	endtask

	// wait until every item is in and every result is out, then let the pipe settle
	task automatic drain_all();
		while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic item_t pkt(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
		logic [15:0] dp, logic [7:0] pr, logic [15:0] sz, logic [31:0] now);
		item_t it;
		it = '0;
		it.cmd = CMD_PKT;
		it.src_addr = sa; it.dst_addr = da; it.sport = sp; it.dport = dp;
		it.proto = pr; it.pkt_size = sz; it.now_seconds = now;
		it.sweep_bucket = 8'($urandom);
		return it;
	endfunction

	function automatic item_t rand_pkt();
		return pkt($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
			16'($urandom), $urandom);
	endfunction

	function automatic item_t sweep(logic [7:0] b, logic [31:0] now);
		item_t it;
		it = rand_pkt();
		it.now_seconds = now;
		it.cmd = CMD_SWEEP;
		it.sweep_bucket = b;
		return it;
	endfunction

	// colliding tuples: same hash bucket, found by searching over source ports
	item_t coll [$];

	initial begin
		item_t it, base;
		int tb;
		logic [31:0] t;
		item_t flows [$];
		foreach (flow_tab[i]) flow_tab[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, forward/reverse, backward time
		it = pkt('1, '1, '1, '1, '1, '1, 32'd100);
		pending_items.push_back(it);
		pending_items.push_back(pkt('1, '1, '1, '1, '1, '1, 32'd90));
		pending_items.push_back(pkt('0, '0, '0, '0, '0, '0, 32'd0));
		pending_items.push_back(pkt(32'h0a000001, 32'h0a000002, 16'd1234, 16'd80, 8'd6,
			16'd1500, 32'd10));
		pending_items.push_back(pkt(32'h0a000002, 32'h0a000001, 16'd80, 16'd1234, 8'd6,
			16'd40, 32'd12));
		pending_items.push_back(pkt(32'h0a000002, 32'h0a000001, 16'd80, 16'd1234, 8'd17,
			16'd40, 32'd13));
		// fill one bucket past its ways to force a drop
		base = pkt(32'hc0a80001, 32'h08080808, 16'd5000, 16'd53, 8'd17, 16'd64, 32'd20);
		tb = bucket_hash(base);
		coll.push_back(base);
		for (int k = 1; k < 400000 && coll.size() < 6; k++) begin
			it = base;
			it.sport = 16'(k);
			if (bucket_hash(it) == tb) coll.push_back(it);
		end
		foreach (coll[i]) pending_items.push_back(coll[i]);
		pending_items.push_back(sweep(8'(tb), 32'd21));
		pending_items.push_back(sweep(8'(tb), 32'hffffffff));
		pending_items.push_back(sweep(8'(tb), 32'd0));
		pending_items.push_back(sweep('1, 32'd5));
		drain_all();

		// extreme settings
		write_reg(REG_IDLE_TO, 32'd0);
		write_reg(REG_ACTIVE_TO, 32'hffffffff);
		write_reg(REG_UNUSED, 32'h12345678);
		foreach (coll[i]) begin
			it = coll[i];
			it.now_seconds = 32'd50;
			pending_items.push_back(it);
		end
		pending_items.push_back(sweep(8'(tb), 32'd50));
		pending_items.push_back(sweep(8'(tb), 32'd51));
		drain_all();
		write_reg(REG_IDLE_TO, 32'hffffffff);
		write_reg(REG_ACTIVE_TO, 32'd0);
		// counters near saturation are unreachable quickly; pump a flow hard
		for (int i = 0; i < 6; i++) pending_items.push_back(pkt(32'h1, 32'h2, 16'd3, 16'd4,
			8'd6, 16'hffff, 32'd200 + i));
		pending_items.push_back(sweep(8'(bucket_hash(pkt(32'h1, 32'h2, 16'd3, 16'd4, 8'd6,
			16'd0, 32'd0))), 32'd300));

		// receiver holds off while the sender keeps offering
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++)
			pending_items.push_back(rand_pkt());
		drain_all();

		// random phases with different settings and idle mixes
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 64 : 0;
			recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 25 : 0;
			write_reg(REG_IDLE_TO, $urandom_range(40, 5));
			write_reg(REG_ACTIVE_TO, $urandom_range(150, 20));
			flows.delete();
			for (int i = 0; i < 10; i++)
				flows.push_back(pkt($urandom, $urandom, 16'($urandom), 16'($urandom),
					$urandom_range(1) ? 8'd6 : 8'd17, 16'd0, 32'd0));
			t = $urandom_range(1000);
			for (int i = 0; i < 15; i++) begin
				t += $urandom_range(12);
				if ($urandom_range(9) < 2) begin
					pending_items.push_back(sweep(8'(bucket_hash(flows[$urandom_range(9)])), t));
				end else if ($urandom_range(9) == 0) begin
					pending_items.push_back(rand_pkt());
				end else begin
					it = flows[$urandom_range(9)];
					if ($urandom_range(1)) begin
						it = flows[$urandom_range(9)];
						{it.src_addr, it.dst_addr} = {it.dst_addr, it.src_addr};
						{it.sport, it.dport} = {it.dport, it.sport};
					end
					it.pkt_size = 16'($urandom);
					it.now_seconds = ($urandom_range(19) == 0) ? t - 5 : t;
					it.sweep_bucket = 8'($urandom);
					pending_items.push_back(it);
				end
			end
			// sweep the bucket of every flow far in the future to flush
			foreach (flows[i]) pending_items.push_back(sweep(8'(bucket_hash(flows[i])), '1));
			drain_all();
		end

		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/bft_pkg.sv
hw/rtl/bft_ram.sv
hw/rtl/bft_fifo.sv
hw/rtl/bft_front.sv
hw/rtl/bft_back.sv
hw/rtl/bidirectional_flow_table.sv
verif/tb_bidirectional_flow_table.sv
